FILE: hw/rtl/pfba_pkg.sv
// shared types and constants of the page frame bitmap allocator
package pfba_pkg;

    localparam int FRAME_SHIFT = 12;
    localparam int FRAME_W     = 32 - FRAME_SHIFT;
    localparam int SPAN_W      = FRAME_W + 1;
    localparam int CMP_W       = SPAN_W + 1;
    localparam int CFG_IDX_W   = 3;

    localparam logic [31:0]       TYPE_AVAILABLE = 32'd1;
    localparam logic [SPAN_W-1:0] FRAME_TOP      = SPAN_W'(1) << FRAME_W;

    localparam logic [CFG_IDX_W-1:0] CFG_R0_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_R0_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R0_TYPE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_R1_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_R1_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_R1_TYPE   = 3'd5;

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic span_a;
        logic span_b;
        logic total_ld;
        logic scan_init;
        logic rd_scan;
        logic scan_next;
        logic wr_set;
        logic map_ld;
        logic free_cmp;
        logic free_pos;
        logic rd_free;
        logic wr_clr;
        logic res_ld;
    } pfba_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic scan_end;
        logic word_full;
        logic scan_ok;
        logic free_hit;
        logic out_full;
    } pfba_sts_t;

endpackage

FILE: hw/rtl/pfba_ctrl.sv
// sequencer of the page frame allocator: clear pass, allocate scan, free
module pfba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pfba_pkg::pfba_sts_t sts,
    output pfba_pkg::pfba_cmd_t cmd
);
    import pfba_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR     = 13'b0000000000001,
        S_IDLE      = 13'b0000000000010,
        S_SPAN_A    = 13'b0000000000100,
        S_SPAN_B    = 13'b0000000001000,
        S_TOTAL     = 13'b0000000010000,
        S_ALLOC_RD  = 13'b0000000100000,
        S_ALLOC_CHK = 13'b0000001000000,
        S_ALLOC_MAP = 13'b0000010000000,
        S_FREE_CMP  = 13'b0000100000000,
        S_FREE_POS  = 13'b0001000000000,
        S_FREE_RD   = 13'b0010000000000,
        S_FREE_WR   = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SPAN_A;
                end
            end
            S_SPAN_A: begin
                cmd.span_a = 1'b1;
                state_next = S_SPAN_B;
            end
            S_SPAN_B: begin
                cmd.span_b = 1'b1;
                state_next = S_TOTAL;
            end
            S_TOTAL: begin
                cmd.total_ld = 1'b1;
                if (sts.is_free) begin
                    state_next = S_FREE_CMP;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_ALLOC_RD;
                end
            end
            S_ALLOC_RD: begin
                if (sts.scan_end) begin
                    state_next = S_DONE;
                end else begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_ALLOC_CHK;
                end
            end
            S_ALLOC_CHK: begin
                if (sts.word_full) begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_ALLOC_RD;
                end else if (sts.scan_ok) begin
                    cmd.wr_set = 1'b1;
                    state_next = S_ALLOC_MAP;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_ALLOC_MAP: begin
                cmd.map_ld = 1'b1;
                state_next = S_DONE;
            end
            S_FREE_CMP: begin
                cmd.free_cmp = 1'b1;
                state_next   = S_FREE_POS;
            end
            S_FREE_POS: begin
                cmd.free_pos = 1'b1;
                state_next   = S_FREE_RD;
            end
            S_FREE_RD: begin
                if (sts.free_hit) begin
                    cmd.rd_free = 1'b1;
                    state_next  = S_FREE_WR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_FREE_WR: begin
                cmd.wr_clr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_full) begin
                    cmd.res_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && s_tvalid) |=> (state_reg == S_SPAN_A))
        else $error("accepted transaction did not start span setup");

    a_scan_is_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC_RD) |-> !sts.is_free)
        else $error("bitmap scan running for a free request");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_ld |-> !sts.out_full)
        else $error("result loaded over an untaken result");

endmodule

FILE: hw/rtl/pfba_dp.sv
// datapath of the page frame allocator: config, region spans, bitmap memory, result
module pfba_dp #(
    parameter int MAX_FRAMES      = 65536,
    parameter int LOW_FRAME_LIMIT = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               s_tuser,
    input  logic [31:0]                        s_tdata,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [31:0]                        m_tdata,
    output logic                               m_tuser,
    input  pfba_pkg::pfba_cmd_t                cmd,
    output pfba_pkg::pfba_sts_t                sts
);
    import pfba_pkg::*;

    localparam int BITMAP_WORDS = (MAX_FRAMES + 31) / 32;
    localparam int WORD_W       = $clog2(BITMAP_WORDS);
    localparam int CNT_W        = WORD_W + 1;
    localparam int POS_W        = WORD_W + 5;
    localparam logic [SPAN_W-1:0] LOW_C = SPAN_W'(LOW_FRAME_LIMIT);
    localparam logic [CMP_W-1:0]  MAX_C = CMP_W'(MAX_FRAMES);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(BITMAP_WORDS - 1);

    function automatic logic [4:0] first_zero(input logic [31:0] word);
        logic [31:0] inv;
        logic [31:0] iso;
        logic [4:0]  idx;
        inv = ~word;
        iso = inv & (~inv + 32'd1);
        idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (iso[i]) begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

    // configuration, only the frame part of base and length is kept
    logic [FRAME_W-1:0] base_reg [2];
    logic [FRAME_W-1:0] len_reg  [2];
    logic [31:0]        type_reg [2];

    // span setup stages
    logic [SPAN_W-1:0]  end_reg   [2];
    logic [SPAN_W-1:0]  start_reg [2];
    logic               avail_reg [2];
    logic [SPAN_W-1:0]  first_reg [2];
    logic [SPAN_W-1:0]  count_reg [2];
    logic [SPAN_W-1:0]  total_reg;
    logic [FRAME_W-1:0] off1_reg;

    logic               action_reg;
    logic [FRAME_W-1:0] frame_in_reg;
    logic [SPAN_W-1:0]  dist_reg [2];
    logic               ge_reg   [2];
    logic [SPAN_W-1:0]  pos_reg;
    logic               hit_reg;

    logic [CNT_W-1:0]   scan_reg;
    logic [WORD_W-1:0]  clr_reg;
    logic [31:0]        rdata_reg;
    logic [31:0]        bitmap_mem [BITMAP_WORDS];

    logic [FRAME_W-1:0] res_frame_reg;
    logic               res_ok_reg;
    logic               m_tvalid_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic               out_ok_reg;

    logic [4:0]         zero_bit;
    logic [POS_W-1:0]   scan_pos;
    logic [WORD_W-1:0]  scan_idx;
    logic [WORD_W-1:0]  free_idx;
    logic               mem_we;
    logic [WORD_W-1:0]  mem_waddr;
    logic [31:0]        mem_wdata;
    logic [WORD_W-1:0]  mem_raddr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 2; r++) begin
                base_reg[r] <= '0;
                len_reg[r]  <= '0;
                type_reg[r] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_R0_BASE:   base_reg[0] <= cfg_data[31:FRAME_SHIFT];
                CFG_R0_LENGTH: len_reg[0]  <= cfg_data[31:FRAME_SHIFT];
                CFG_R0_TYPE:   type_reg[0] <= cfg_data;
                CFG_R1_BASE:   base_reg[1] <= cfg_data[31:FRAME_SHIFT];
                CFG_R1_LENGTH: len_reg[1]  <= cfg_data[31:FRAME_SHIFT];
                CFG_R1_TYPE:   type_reg[1] <= cfg_data;
                default: ;
            endcase
        end
    end

    // region spans, clipped to the top of the address space and the low limit
    always_ff @(posedge aclk) begin
        for (int r = 0; r < 2; r++) begin
            if (cmd.span_a) begin
                logic [SPAN_W-1:0] e_raw;
                e_raw = {1'b0, base_reg[r]} + {1'b0, len_reg[r]};
                end_reg[r]   <= (e_raw > FRAME_TOP) ? FRAME_TOP : e_raw;
                avail_reg[r] <= (type_reg[r] == TYPE_AVAILABLE) && (e_raw >= LOW_C);
                start_reg[r] <= ({1'b0, base_reg[r]} < LOW_C) ? LOW_C : {1'b0, base_reg[r]};
            end
            if (cmd.span_b) begin
                if (avail_reg[r] && (end_reg[r] > start_reg[r])) begin
                    first_reg[r] <= start_reg[r];
                    count_reg[r] <= end_reg[r] - start_reg[r];
                end else begin
                    first_reg[r] <= '0;
                    count_reg[r] <= '0;
                end
            end
        end
        if (cmd.total_ld) begin
            logic [CMP_W-1:0] sum;
            sum = {1'b0, count_reg[0]} + {1'b0, count_reg[1]};
            total_reg <= SPAN_W'((sum > MAX_C) ? MAX_C : sum);
            // frame of a region 1 position is pos plus this offset, mod 2^20
            off1_reg  <= first_reg[1][FRAME_W-1:0] - count_reg[0][FRAME_W-1:0];
        end
    end

    // input capture and free lookup
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg   <= s_tuser;
            frame_in_reg <= s_tdata[31:FRAME_SHIFT];
        end
        if (cmd.free_cmp) begin
            for (int r = 0; r < 2; r++) begin
                ge_reg[r]   <= ({1'b0, frame_in_reg} >= first_reg[r]);
                dist_reg[r] <= {1'b0, frame_in_reg} - first_reg[r];
            end
        end
        if (cmd.free_pos) begin
            logic h0;
            logic h1;
            h0 = (count_reg[0] != '0) && ge_reg[0] && (dist_reg[0] < count_reg[0]);
            h1 = (count_reg[1] != '0) && ge_reg[1] && (dist_reg[1] < count_reg[1]);
            hit_reg <= h0 || h1;
            pos_reg <= h0 ? dist_reg[0] : (count_reg[0] + dist_reg[1]);
        end else if (cmd.wr_set) begin
            pos_reg <= SPAN_W'(scan_pos);
        end
    end

    assign zero_bit = first_zero(rdata_reg);
    assign scan_idx = scan_reg[WORD_W-1:0];
    assign scan_pos = {scan_idx, zero_bit};
    assign free_idx = pos_reg[POS_W-1:5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
            clr_reg  <= '0;
        end else begin
            if (cmd.scan_init) begin
                scan_reg <= '0;
            end else if (cmd.scan_next) begin
                scan_reg <= scan_reg + CNT_W'(1);
            end
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + WORD_W'(1);
            end
        end
    end

    // one write and one read port, read data registered
    always_comb begin
        mem_we    = cmd.clr_step || cmd.wr_set || cmd.wr_clr;
        mem_waddr = free_idx;
        mem_wdata = rdata_reg & ~(32'd1 << pos_reg[4:0]);
        if (cmd.clr_step) begin
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end else if (cmd.wr_set) begin
            mem_waddr = scan_idx;
            mem_wdata = rdata_reg | (32'd1 << zero_bit);
        end
        mem_raddr = cmd.rd_free ? free_idx : scan_idx;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_scan || cmd.rd_free) begin
            rdata_reg <= bitmap_mem[mem_raddr];
        end
    end

    // result of the current transaction
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            res_ok_reg    <= 1'b0;
            res_frame_reg <= '0;
        end else if (cmd.map_ld) begin
            res_ok_reg    <= 1'b1;
            res_frame_reg <= (pos_reg < count_reg[0])
                           ? first_reg[0][FRAME_W-1:0] + pos_reg[FRAME_W-1:0]
                           : off1_reg + pos_reg[FRAME_W-1:0];
        end else if (cmd.wr_clr) begin
            res_ok_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_ld) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_ld) begin
            out_frame_reg <= res_frame_reg;
            out_ok_reg    <= res_ok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_frame_reg, {FRAME_SHIFT{1'b0}}};
    assign m_tuser  = out_ok_reg;

    always_comb begin
        sts.clr_done  = (clr_reg == LAST_WORD);
        sts.is_free   = action_reg;
        sts.scan_end  = (CMP_W'({scan_reg, 5'b0}) >= {1'b0, total_reg});
        sts.word_full = (rdata_reg == '1);
        sts.scan_ok   = (CMP_W'(scan_pos) < {1'b0, total_reg});
        sts.free_hit  = hit_reg && (pos_reg < total_reg);
        sts.out_full  = m_tvalid_reg && !m_tready;
    end

    a_frame_above_low: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.map_ld |=> (res_ok_reg && ({1'b0, res_frame_reg} >= LOW_C)))
        else $error("allocated frame below the low frame limit");

    a_set_in_free_word: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_set |-> (rdata_reg != '1))
        else $error("used bit set in a full bitmap word");

    a_clear_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_clr |-> (hit_reg && (pos_reg < total_reg)))
        else $error("bitmap bit cleared without a matching position");

endmodule

FILE: hw/rtl/page_frame_bitmap_allocator.sv
// First-fit 4 KiB page frame allocator over two memory regions. After reset a
// clearing pass writes the used bitmap, one 32-bit word per cycle, over all
// (MAX_FRAMES+31)/32 words (2048 at the default) before the first transaction
// is taken; configuration writes are accepted throughout. Every request goes
// through region span setup in S_SPAN_A, S_SPAN_B and S_TOTAL. An allocate
// then reads the bitmap word by word through a memory with one write and one
// read port and registered read data, reading each word in S_ALLOC_RD and
// checking it in S_ALLOC_CHK; a usable clear bit is set and mapped to a frame.
// A free locates the frame in the regions and, when found, reads and clears
// its bit. One transaction is worked at a time; the result sits in an output
// register, so the next request is taken while it waits for m_tready, and a
// finished transaction only holds while the previous result is still untaken.
module page_frame_bitmap_allocator #(
    parameter int MAX_FRAMES      = 65536,
    parameter int LOW_FRAME_LIMIT = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] address
    input  logic                           s_tuser,   // [0] action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [31:0] frame_address
    output logic                           m_tuser    // [0] result_ok
);
    import pfba_pkg::*;

    pfba_cmd_t cmd;
    pfba_sts_t sts;

    pfba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfba_dp #(
        .MAX_FRAMES      (MAX_FRAMES),
        .LOW_FRAME_LIMIT (LOW_FRAME_LIMIT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: sim/page_frame_bitmap_allocator_test_pkg.sv
// request codes shared by the allocator testbench modules
`timescale 1ns / 100ps

package pfba_test_pkg;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

endpackage

FILE: sim/page_frame_bitmap_allocator_checker.sv
// scoreboard for the allocator: tracks regions and used map, predicts and compares replies
`timescale 1ns / 100ps

module page_frame_bitmap_allocator_checker #(
    parameter int MAX_FRAMES      = 65536,
    parameter int LOW_FRAME_LIMIT = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] address
    input  logic                           s_tuser,   // [0] action
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [31:0]                    m_tdata,   // [31:0] frame_address
    input  logic                           m_tuser,   // [0] result_ok
    output int                             mismatches,
    output int                             replies_owed
);
    import pfba_pkg::*;
    import pfba_test_pkg::*;

    typedef struct {
        logic [31:0] frame_address;
        logic        result_ok;
        logic        action;
    } alloc_reply_t;

    logic [31:0]  region_base   [2];
    logic [31:0]  region_length [2];
    logic [31:0]  region_type   [2];
    bit           used_map      [MAX_FRAMES];
    alloc_reply_t replies_due   [$];
    int           error_total;

    // usable frame span of one region after type check, top clip and low-memory clip
    function automatic void region_span(input int r, output int unsigned lo_frame,
                                        output int unsigned n_frames);
        int unsigned b;
        int unsigned e;
        b = region_base[r] >> FRAME_SHIFT;
        e = b + (region_length[r] >> FRAME_SHIFT);
        lo_frame = 0;
        n_frames = 0;
        if (region_type[r] == TYPE_AVAILABLE) begin
            if (e > FRAME_TOP) e = FRAME_TOP;
            if (e >= LOW_FRAME_LIMIT) begin
                if (b < LOW_FRAME_LIMIT) b = LOW_FRAME_LIMIT;
                if (e > b) begin
                    lo_frame = b;
                    n_frames = e - b;
                end
            end
        end
    endfunction

    function automatic alloc_reply_t predict_reply(input logic action, input logic [31:0] addr);
        int unsigned  f0, n0, f1, n1, total, frame, pos;
        bit           hit;
        alloc_reply_t res;
        region_span(0, f0, n0);
        region_span(1, f1, n1);
        total = n0 + n1;
        if (total > MAX_FRAMES) total = MAX_FRAMES;
        res.frame_address = '0;
        res.result_ok     = 1'b0;
        res.action        = action;
        hit               = 1'b0;
        pos               = 0;
        if (action == ACT_ALLOC) begin
            while (pos < total && used_map[pos]) pos++;
            if (pos < total) begin
                used_map[pos] = 1'b1;
                frame = (pos < n0) ? f0 + pos : f1 + (pos - n0);
                res.frame_address = frame << FRAME_SHIFT;
                res.result_ok     = 1'b1;
            end
        end else begin
            frame = addr >> FRAME_SHIFT;
            // region 0 wins where the two overlap
            if (n0 != 0 && frame >= f0 && frame - f0 < n0) begin
                pos = frame - f0;
                hit = 1'b1;
            end else if (n1 != 0 && frame >= f1 && frame - f1 < n1) begin
                pos = n0 + (frame - f1);
                hit = 1'b1;
            end
            if (hit && pos < total) begin
                used_map[pos] = 1'b0;
                res.result_ok = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        alloc_reply_t want;
        if (!aresetn) begin
            region_base   = '{default: '0};
            region_length = '{default: '0};
            region_type   = '{default: '0};
            used_map      = '{default: 1'b0};
            replies_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_R0_BASE:   region_base[0]   = cfg_data;
                    CFG_R0_LENGTH: region_length[0] = cfg_data;
                    CFG_R0_TYPE:   region_type[0]   = cfg_data;
                    CFG_R1_BASE:   region_base[1]   = cfg_data;
                    CFG_R1_LENGTH: region_length[1] = cfg_data;
                    CFG_R1_TYPE:   region_type[1]   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(predict_reply(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    error_total++;
                    if (error_total <= 10)
                        $display("%0t: reply addr %h ok %b with no request pending",
                                 $realtime, m_tdata, m_tuser);
                end else begin
                    want = replies_due.pop_front();
                    if (m_tdata !== want.frame_address || m_tuser !== want.result_ok) begin
                        error_total++;
                        if (error_total <= 10)
                            $display("%0t: %s expected addr %h ok %b, got addr %h ok %b",
                                     $realtime, (want.action == ACT_ALLOC) ? "allocate" : "free",
                                     want.frame_address, want.result_ok, m_tdata, m_tuser);
                    end
                end
            end
        end
        replies_owed <= replies_due.size();
        mismatches   <= error_total;
    end

endmodule

FILE: sim/page_frame_bitmap_allocator_test.sv
// top of the allocator testbench: clock, reset, region settings, request stream and verdict
`timescale 1ns / 100ps

module page_frame_bitmap_allocator_test;

    import pfba_pkg::*;
    import pfba_test_pkg::*;

    localparam int MAX_FRAMES      = 65536;
    localparam int LOW_FRAME_LIMIT = 1024;
    localparam int RANDOM_ITEMS    = 850;
    localparam int QUIET_FROM      = 760;

    // indexes past the last region register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;   // [31:0] address
    logic                 s_tuser;   // [0] action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // [31:0] frame_address
    logic                 m_tuser;   // [0] result_ok

    int          mismatches;
    int          replies_owed;
    logic [31:0] granted_frames [$];
    bit          quiet_tail;
    int          stall_left;
    int          alloc_sent;
    int          free_sent;
    int          ok_seen;
    int          settings_loaded;

    page_frame_bitmap_allocator #(
        .MAX_FRAMES      (MAX_FRAMES),
        .LOW_FRAME_LIMIT (LOW_FRAME_LIMIT)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    page_frame_bitmap_allocator_checker #(
        .MAX_FRAMES      (MAX_FRAMES),
        .LOW_FRAME_LIMIT (LOW_FRAME_LIMIT)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .replies_owed (replies_owed)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // receiver stalls in random bursts, none in the tail
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // keep granted addresses so frees mostly target live frames
    always @(posedge aclk) begin
        if (m_tvalid && m_tready && m_tuser) begin
            ok_seen++;
            if (m_tdata != 32'h0) granted_frames.push_back(m_tdata);
        end
    end

    task automatic put_request(input logic action, input logic [31:0] addr);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= addr;
        if (action == ACT_ALLOC) alloc_sent++;
        else free_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off new requests until every reply is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic load_regions(input logic [31:0] b0, l0, t0, b1, l1, t1);
        cfg_write(CFG_R0_BASE, b0);
        cfg_write(CFG_R0_LENGTH, l0);
        cfg_write(CFG_R0_TYPE, t0);
        cfg_write(CFG_R1_BASE, b1);
        cfg_write(CFG_R1_LENGTH, l1);
        cfg_write(CFG_R1_TYPE, t1);
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom());
        cfg_we <= 1'b0;
        granted_frames.delete();
        settings_loaded++;
    endtask

    // short region, often straddling the low-memory limit, now and then disabled
    task automatic small_region(output logic [31:0] base, len, kind);
        int unsigned frame;
        frame = $urandom_range(0, 1) ? $urandom_range(1000, 1100)
                                     : $urandom_range(LOW_FRAME_LIMIT, 32'hFFF00);
        base  = (frame << FRAME_SHIFT) | $urandom_range(0, 4095);
        len   = ($urandom_range(0, 60) << FRAME_SHIFT) | $urandom_range(0, 4095);
        if ($urandom_range(0, 7) == 0) kind = $urandom_range(0, 1) ? $urandom() : 32'h0;
        else kind = TYPE_AVAILABLE;
    endtask

    task automatic random_regions();
        logic [31:0] b0, l0, t0, b1, l1, t1;
        int unsigned style;
        small_region(b0, l0, t0);
        small_region(b1, l1, t1);
        style = $urandom_range(0, 9);
        case (style)
            5: b1 = b0 + ($urandom_range(0, 8) << FRAME_SHIFT);
            6: begin
                b1 = (32'hFFFF_F000 - ($urandom_range(0, 40) << FRAME_SHIFT))
                     | $urandom_range(0, 4095);
                l1 = $urandom();
                t1 = TYPE_AVAILABLE;
            end
            7: begin
                b0 = $urandom_range(0, 1100) << FRAME_SHIFT;
                l0 = 32'hFFFF_FFFF;
                t0 = TYPE_AVAILABLE;
            end
            8: begin
                b0 = $urandom();
                l0 = $urandom();
                b1 = $urandom();
                l1 = $urandom();
                if ($urandom_range(0, 1)) t0 = TYPE_AVAILABLE;
                if ($urandom_range(0, 1)) t1 = TYPE_AVAILABLE;
            end
            9: begin
                // ends below the low-memory limit, so it drops out
                b0 = $urandom_range(0, 900) << FRAME_SHIFT;
                l0 = $urandom_range(0, 100) << FRAME_SHIFT;
                t0 = TYPE_AVAILABLE;
            end
            default: ;
        endcase
        load_regions(b0, l0, t0, b1, l1, t1);
    endtask

    initial begin : stimulus
        int          random_sent;
        int          phase_len;
        int          roll;
        int          k;
        logic [31:0] addr;

        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = ACT_ALLOC;
        quiet_tail      = 1'b0;
        alloc_sent      = 0;
        free_sent       = 0;
        settings_loaded = 0;
        random_sent     = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset regions are not available: everything fails
        put_request(ACT_ALLOC, 32'h0);
        put_request(ACT_FREE, 32'hFFFF_FFFF);
        drain();

        // two frames clipped at the low limit, two at the top of the address space
        load_regions(32'h003F_E000, 32'h0000_4FFF, TYPE_AVAILABLE,
                     32'hFFFF_E000, 32'hFFFF_FFFF, TYPE_AVAILABLE);
        repeat (5) put_request(ACT_ALLOC, $urandom());
        put_request(ACT_FREE, 32'h0040_1FFF);
        put_request(ACT_FREE, 32'h0040_1000);
        put_request(ACT_ALLOC, 32'h0);
        put_request(ACT_FREE, 32'h003F_F000);
        put_request(ACT_FREE, 32'hFFFF_FFFF);
        put_request(ACT_FREE, 32'h0);
        drain();

        // overlapping regions, old used bits now map to other frames
        load_regions(32'h0050_0000, 32'h0000_3000, TYPE_AVAILABLE,
                     32'h0050_1000, 32'h0000_3000, TYPE_AVAILABLE);
        put_request(ACT_ALLOC, 32'h0);
        put_request(ACT_FREE, 32'h0050_1000);
        put_request(ACT_ALLOC, 32'h0);
        put_request(ACT_ALLOC, 32'hFFFF_FFFF);
        drain();

        // more frames than positions: the last position is usable, the next is not
        load_regions(32'h0040_0000, 32'hFFFF_FFFF, TYPE_AVAILABLE,
                     32'h0000_0000, 32'h0100_0000, TYPE_AVAILABLE);
        put_request(ACT_FREE, 32'h103F_F000);
        put_request(ACT_FREE, 32'h1040_0000);
        put_request(ACT_ALLOC, 32'h0);
        drain();

        // empty span and a span wholly under the low limit
        load_regions(32'h0060_0000, 32'h0000_0FFF, TYPE_AVAILABLE,
                     32'h0000_0000, 32'h003F_F000, TYPE_AVAILABLE);
        put_request(ACT_ALLOC, 32'h0);
        put_request(ACT_FREE, 32'h0060_0000);
        drain();

        // region 0 of a foreign type
        load_regions(32'h0060_0000, 32'h0001_0000, 32'hFFFF_FFFF,
                     32'h0070_0000, 32'h0000_2000, TYPE_AVAILABLE);
        put_request(ACT_ALLOC, 32'h0);
        put_request(ACT_FREE, 32'h0070_0000);

        while (random_sent < RANDOM_ITEMS) begin
            drain();
            random_regions();
            phase_len = $urandom_range(15, 60);
            for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
                quiet_tail = (random_sent >= QUIET_FROM);
                roll = $urandom_range(0, 99);
                if (roll < 50) begin
                    put_request(ACT_ALLOC, $urandom());
                end else if (roll < 85 && granted_frames.size() != 0) begin
                    k    = $urandom_range(0, granted_frames.size() - 1);
                    addr = granted_frames[k] | $urandom_range(0, 4095);
                    granted_frames.delete(k);
                    put_request(ACT_FREE, addr);
                end else begin
                    addr = $urandom_range(0, 1) ? $urandom()
                         : ($urandom_range(1000, 1100) << FRAME_SHIFT) | $urandom_range(0, 4095);
                    put_request(ACT_FREE, addr);
                end
                random_sent++;
            end
        end

        drain();
        repeat (16) @(posedge aclk);
        $display("covered %0d allocate and %0d free transactions under %0d region settings",
                 alloc_sent, free_sent, settings_loaded);
        $display("%0d replies reported success, incl. clipped, overlapping and full regions",
                 ok_seen);
        if (mismatches == 0 && replies_owed == 0) begin
            $display("page_frame_bitmap_allocator_test: PASS");
        end else begin
            $display("page_frame_bitmap_allocator_test: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("timeout with %0d replies still owed", replies_owed);
        $display("page_frame_bitmap_allocator_test: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/pfba_pkg.sv
hw/rtl/pfba_ctrl.sv
hw/rtl/pfba_dp.sv
hw/rtl/page_frame_bitmap_allocator.sv
sim/page_frame_bitmap_allocator_test_pkg.sv
sim/page_frame_bitmap_allocator_checker.sv
sim/page_frame_bitmap_allocator_test.sv
